### hdl/env_pkg.sv
`default_nettype none

package env_pkg;

    localparam int unsigned LEN_W  = 12;
    localparam int unsigned CHAR_W = 8;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd255;

    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;  // '_'
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;  // '-'

    localparam logic [1:0] SEG_CNT_MIN = 2'd2;

    typedef enum logic [1:0] {
        SEG_EMPTY  = 2'd0,
        SEG_DOT    = 2'd1,
        SEG_DOTDOT = 2'd2,
        SEG_OTHER  = 2'd3
    } t_seg_class;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        t_seg_class       cls;
        logic [1:0]       cnt;
        logic             rej;
    } t_name_state;

    // one item after the input register
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              empty_name;
    } t_char_beat;

    localparam t_name_state NAME_STATE_RESET = '{
        len: '0, cls: SEG_EMPTY, cnt: 2'd0, rej: 1'b0
    };

    function automatic logic is_allowed(input logic [CHAR_W-1:0] c);
        logic lower, upper, digit;
        lower = (c >= 8'h61) && (c <= 8'h7A);
        upper = (c >= 8'h41) && (c <= 8'h5A);
        digit = (c >= 8'h30) && (c <= 8'h39);
        return lower || upper || digit || (c == CH_DOT) || (c == CH_UNDER)
            || (c == CH_DASH);
    endfunction

endpackage

`default_nettype wire

### hdl/entry_name_validator_unit.sv
// Channel | Handshake                         | Beat fields
// --------+-----------------------------------+------------------------------------
// in      | i_in_valid / o_in_stall           | i_char_code, i_last, i_empty_name
// out     | o_out_valid / i_out_stall         | o_valid_res
// cfg     | i_cfg_we (no wait)                | i_max_name_length
//
// One character beat per cycle while o_in_stall is low. A beat lands in the
// input register; when it advances, it updates the name state and a final
// beat loads the verdict into the result register, which offers it on out.
// Reset (i_rst_n low, synchronous) empties both registers, clears the name
// state and loads a limit of 255.
// A stall on out only holds the input side when a verdict beat waits behind a
// full output register; character beats that end no name keep flowing.
`default_nettype none

module entry_name_validator_unit (
    input  var logic                      i_clk,
    input  var logic                      i_rst_n,
    input  var logic                      i_cfg_we,
    input  var logic [env_pkg::LEN_W-1:0] i_max_name_length,
    input  var logic                      i_in_valid,
    output var logic                      o_in_stall,
    input  var logic [7:0]                i_char_code,
    input  var logic                      i_last,
    input  var logic                      i_empty_name,
    output var logic                      o_out_valid,
    input  var logic                      i_out_stall,
    output var logic                      o_valid_res
);
    import env_pkg::*;

    logic [LEN_W-1:0] r_max_len;

    // input register
    logic       r_in_vld;
    t_char_beat r_beat;

    // running name state
    t_name_state r_state;
    t_name_state n_state;

    // result register
    logic r_out_vld;
    logic r_res;

    logic step_done;
    logic step_ok;
    logic advance;
    logic in_take;
    logic out_free;

    env_char_step u_step (
        .i_state   (r_state),
        .i_beat    (r_beat),
        .i_max_len (r_max_len),
        .o_state   (n_state),
        .o_done    (step_done),
        .o_ok      (step_ok)
    );

    // the result slot is free if empty or being drained this edge
    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && (!step_done || out_free);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_max_name_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_beat.char_code  <= i_char_code;
            r_beat.last       <= i_last;
            r_beat.empty_name <= i_empty_name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NAME_STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && step_done) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_done) begin
            r_res <= step_ok;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_valid_res = r_res;

endmodule

`default_nettype wire

### hdl/env_char_step.sv
`default_nettype none

module env_char_step (
    input  var env_pkg::t_name_state       i_state,
    input  var env_pkg::t_char_beat        i_beat,
    input  var logic [env_pkg::LEN_W-1:0]  i_max_len,
    output var env_pkg::t_name_state       o_state,
    output var logic                       o_done,
    output var logic                       o_ok
);
    import env_pkg::*;

    t_name_state s_take;
    t_name_state s_close;

    // per-character update
    always_comb begin
        s_take = i_state;
        if (!i_beat.empty_name) begin
            if (i_state.len >= i_max_len) begin
                s_take.rej = 1'b1;
            end else begin
                s_take.len = i_state.len + LEN_W'(1);
            end
            if (i_beat.char_code == CH_SLASH) begin
                if (i_state.cls != SEG_OTHER) s_take.rej = 1'b1;
                if (i_state.cnt < SEG_CNT_MIN) s_take.cnt = i_state.cnt + 2'd1;
                s_take.cls = SEG_EMPTY;
            end else if (!is_allowed(i_beat.char_code)) begin
                s_take.rej = 1'b1;
                s_take.cls = SEG_OTHER;
            end else if (i_beat.char_code == CH_DOT) begin
                unique case (i_state.cls)
                    SEG_EMPTY: s_take.cls = SEG_DOT;
                    SEG_DOT:   s_take.cls = SEG_DOTDOT;
                    default:   s_take.cls = SEG_OTHER;
                endcase
            end else begin
                s_take.cls = SEG_OTHER;
            end
        end
    end

    // end of name: close the open segment and judge
    always_comb begin
        s_close = s_take;
        if (s_take.cls != SEG_OTHER) s_close.rej = 1'b1;
        if (s_take.cnt < SEG_CNT_MIN) s_close.cnt = s_take.cnt + 2'd1;
        o_done = i_beat.empty_name || i_beat.last;
        o_ok   = !s_close.rej && (s_close.len != '0) && (s_close.cnt >= SEG_CNT_MIN);
        o_state = o_done ? NAME_STATE_RESET : s_take;
    end

endmodule

`default_nettype wire

### hdl/env_checker.sv
`default_nettype none

module env_checker (
    input  var logic                      i_clk,
    input  var logic                      i_rst_n,
    input  var logic                      i_cfg_we,
    input  var logic [env_pkg::LEN_W-1:0] i_max_name_length,
    input  var logic                      i_in_valid,
    input  var logic                      o_in_stall,
    input  var logic [7:0]                i_char_code,
    input  var logic                      i_last,
    input  var logic                      i_empty_name,
    input  var logic                      o_out_valid,
    input  var logic                      i_out_stall,
    input  var logic                      o_valid_res
);

    // a held verdict beat keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_valid_res))
        else $error("verdict beat dropped or changed under stall");

    // input only backs up behind a stalled, full result slot
    a_stall_cause: assert property (@(posedge i_clk)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled verdict");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall active after reset");

    // a new verdict only rises after the input stall was low
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_stall))
        else $error("verdict appeared while input was blocked");

endmodule

bind entry_name_validator_unit env_checker u_env_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cfg_we          (i_cfg_we),
    .i_max_name_length (i_max_name_length),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_char_code       (i_char_code),
    .i_last            (i_last),
    .i_empty_name      (i_empty_name),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_valid_res       (o_valid_res)
);

`default_nettype wire
